### hdl/ising_metropolis_spin_update_core_macros.svh
// Assertion macros shared by the lattice update checker.
// No dependencies; included by files that assert.
`ifndef ISING_METROPOLIS_SPIN_UPDATE_CORE_MACROS_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_CORE_MACROS_SVH

// Clocked property, held off while reset is asserted.
`define ISING_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Expression that must never be true outside reset.
`define ISING_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

### hdl/ising_pkg.sv
// Shared types and constants of the Ising lattice update core.
// No dependencies.
package ising_pkg;

    localparam int COORD_W     = 5;
    localparam int COORD_RANGE = 1 << COORD_W;
    localparam int DRAW_W      = 16;
    localparam int THRESH_W    = 17;
    localparam int CFG_DATA_W  = THRESH_W;
    localparam int CFG_INDEX_W = 1;
    localparam int ENERGY_W    = 5;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_FLIP = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_THRESH_FOUR  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESH_EIGHT = 1'b1;

    typedef logic signed [ENERGY_W-1:0] energy_t;

    typedef struct packed {
        logic    accept;
        energy_t energy_change;
    } eval_t;

    typedef enum logic [4:0] {
        ST_CLEAR      = 5'b00001,
        ST_IDLE       = 5'b00010,
        ST_FETCH_UP   = 5'b00100,
        ST_FETCH_DOWN = 5'b01000,
        ST_WRITE      = 5'b10000
    } state_t;

endpackage

### hdl/ising_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ising_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/ising_eval.sv
// Energy change and Metropolis acceptance for one site and its four neighbors.
// Depends on ising_pkg.
module ising_eval
    import ising_pkg::*;
(
    input  logic                center,
    input  logic [3:0]          neighbors,
    input  logic [DRAW_W-1:0]   uniform_draw,
    input  logic [THRESH_W-1:0] thresh_four,
    input  logic [THRESH_W-1:0] thresh_eight,
    output eval_t               result
);

    logic [3:0]          agree;
    logic [2:0]          agree_count;
    logic [ENERGY_W-1:0] energy_raw;
    logic [THRESH_W-1:0] draw_ext;

    // dE = 4 * (neighbors aligned with the site) - 8
    assign agree       = ~(neighbors ^ {4{center}});
    assign agree_count = 3'(agree[0]) + 3'(agree[1]) + 3'(agree[2]) + 3'(agree[3]);
    assign energy_raw  = {agree_count, 2'b00} - ENERGY_W'(8);
    assign draw_ext    = {1'b0, uniform_draw};

    always_comb
    begin
        result.energy_change = energy_t'(energy_raw);
        priority if (agree_count <= 3'd2)
        begin
            result.accept = 1'b1;
        end
        else if (agree_count == 3'd3)
        begin
            result.accept = (draw_ext < thresh_four);
        end
        else
        begin
            result.accept = (draw_ext < thresh_eight);
        end
    end

endmodule

### hdl/ising_metropolis_spin_update_core.sv
// Ising lattice core: a SIDE x SIDE lattice of one-bit spins with periodic wrap,
// updated by single-site requests. A load request stores one spin; a flip request
// computes dE = 2*s*(sum of the four wrapped neighbors) and flips when dE <= 0,
// or when uniform_draw is below the threshold register for dE = 4 or dE = 8.
// Every request returns exactly one result. Row and column are taken modulo SIDE.
// The lattice lives in one RAM of SIDE rows, SIDE bits each, with a single read
// port, so a flip request reads its own row, the row above and the row below in
// turn and then writes its row back; a load request reads its row, then writes
// it back. A result waiting in the output register does not block the next
// request; only write back waits for the output register to be free. After reset
// the core fills the lattice with +1 spins, one row a cycle, with in_ready low;
// threshold writes are taken at any time. Depends on ising_pkg, ising_ram and
// ising_eval.
module ising_metropolis_spin_update_core
    import ising_pkg::*;
#(
    parameter int SIDE = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   action,
    input  logic [COORD_W-1:0]     row,
    input  logic [COORD_W-1:0]     column,
    input  logic                   load_spin,
    input  logic [DRAW_W-1:0]      uniform_draw,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   spin_after,
    output logic                   flipped,
    output logic signed [ENERGY_W-1:0] energy_change
);

    localparam int CW = (SIDE > 1) ? $clog2(SIDE) : 1;

    // Wrap table for the five-bit coordinates: entry i holds i modulo SIDE.
    logic [CW-1:0] coord_wrap [COORD_RANGE];

    for (genvar g = 0; g < COORD_RANGE; g++)
    begin : g_wrap
        assign coord_wrap[g] = CW'(g % SIDE);
    end

    state_t              state_reg, state_next;
    logic [CW-1:0]       clear_row_reg, clear_row_next;

    logic [THRESH_W-1:0] thresh_four_reg;
    logic [THRESH_W-1:0] thresh_eight_reg;

    // request held for the whole update
    logic                action_reg;
    logic [CW-1:0]       row_reg;
    logic [CW-1:0]       col_reg;
    logic                load_reg;
    logic [DRAW_W-1:0]   draw_reg;
    logic [SIDE-1:0]     mid_row_reg;
    logic                up_bit_reg;

    logic                out_valid_reg, out_valid_next;
    logic                spin_after_reg;
    logic                flipped_reg;
    energy_t             energy_reg;

    logic                in_accept;
    logic                out_free;
    logic                finish;
    logic [CW-1:0]       row_in, col_in;
    logic [CW-1:0]       row_up, row_down, col_left, col_right;

    logic                rd_en;
    logic [CW-1:0]       rd_addr;
    logic [SIDE-1:0]     rd_data;
    logic                wr_en;
    logic [CW-1:0]       wr_addr;
    logic [SIDE-1:0]     wr_data;

    logic                center_bit;
    logic                new_bit;
    logic [SIDE-1:0]     new_row;
    eval_t               eval;

    assign row_in    = coord_wrap[row];
    assign col_in    = coord_wrap[column];
    assign row_up    = (row_reg == '0) ? CW'(SIDE - 1) : row_reg - 1'b1;
    assign row_down  = (row_reg == CW'(SIDE - 1)) ? '0 : row_reg + 1'b1;
    assign col_left  = (col_reg == '0) ? CW'(SIDE - 1) : col_reg - 1'b1;
    assign col_right = (col_reg == CW'(SIDE - 1)) ? '0 : col_reg + 1'b1;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid & in_ready;
    assign out_free  = ~out_valid_reg | out_ready;
    // write back and hand the result over in the same cycle
    assign finish    = (state_reg == ST_WRITE) & out_free;

    ising_ram
    #(
        .WIDTH (SIDE),
        .DEPTH (SIDE)
    )
    u_lattice
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // In ST_WRITE the read port idles, so rd_data still holds the row below.
    assign center_bit = mid_row_reg[col_reg];

    ising_eval u_eval
    (
        .center       (center_bit),
        .neighbors    ({up_bit_reg, rd_data[col_reg],
                        mid_row_reg[col_left], mid_row_reg[col_right]}),
        .uniform_draw (draw_reg),
        .thresh_four  (thresh_four_reg),
        .thresh_eight (thresh_eight_reg),
        .result       (eval)
    );

    always_comb
    begin
        new_bit = (action_reg == ACT_FLIP) ? (center_bit ^ eval.accept) : load_reg;
        new_row = mid_row_reg;
        new_row[col_reg] = new_bit;
    end

    // Read sequencing: own row at accept, then the row above, then the row below.
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_en   = in_accept;
                rd_addr = row_in;
            end
            ST_FETCH_UP:
            begin
                rd_en   = 1'b1;
                rd_addr = row_up;
            end
            ST_FETCH_DOWN:
            begin
                rd_en   = 1'b1;
                rd_addr = row_down;
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = row_reg;
            end
        endcase
    end

    // Write port: fill rows during the clearing pass, else write the row back.
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clear_row_reg;
            wr_data = '1;
        end
        else
        begin
            wr_en   = finish;
            wr_addr = row_reg;
            wr_data = new_row;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clear_row_next = clear_row_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clear_row_next = clear_row_reg + 1'b1;
                if (clear_row_reg == CW'(SIDE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_FETCH_UP;
                end
            end
            ST_FETCH_UP:
            begin
                state_next = (action_reg == ACT_LOAD) ? ST_WRITE : ST_FETCH_DOWN;
            end
            ST_FETCH_DOWN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = finish | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clear_row_reg    <= '0;
            out_valid_reg    <= 1'b0;
            thresh_four_reg  <= '0;
            thresh_eight_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_row_reg <= clear_row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    REG_THRESH_FOUR:  thresh_four_reg  <= cfg_data;
                    REG_THRESH_EIGHT: thresh_eight_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    // Payload: hold the request, capture fetched rows, latch the result.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg <= action;
            row_reg    <= row_in;
            col_reg    <= col_in;
            load_reg   <= load_spin;
            draw_reg   <= uniform_draw;
        end
        if (state_reg == ST_FETCH_UP)
        begin
            mid_row_reg <= rd_data;
        end
        if (state_reg == ST_FETCH_DOWN)
        begin
            up_bit_reg <= rd_data[col_reg];
        end
        if (finish)
        begin
            spin_after_reg <= new_bit;
            flipped_reg    <= (action_reg == ACT_FLIP) & eval.accept;
            energy_reg     <= (action_reg == ACT_FLIP) ? eval.energy_change : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign spin_after    = spin_after_reg;
    assign flipped       = flipped_reg;
    assign energy_change = energy_reg;

endmodule

### hdl/ising_checker.sv
// Port-level checks of the Ising lattice core, bound to the top level.
// Depends on ising_pkg and ising_metropolis_spin_update_core_macros.svh.
`include "ising_metropolis_spin_update_core_macros.svh"

module ising_checker
    import ising_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       spin_after,
    input logic                       flipped,
    input logic signed [ENERGY_W-1:0] energy_change
);

    // in_ready drops after a request is taken, while the core still works on it
    `ISING_ASSERT_CLK(a_request_busy, clk, rst_n, (in_valid && in_ready) |=> !in_ready ##1 !in_ready, "request accepted while the previous one is still at work")

    // a downhill move is always taken
    `ISING_ASSERT_CLK(a_downhill_flips, clk, rst_n, (out_valid && energy_change[ENERGY_W-1]) |-> flipped, "negative energy change without a flip")

    // energy changes come in steps of four
    `ISING_ASSERT_NEVER(a_energy_step, clk, rst_n, out_valid && (energy_change[1:0] != 2'b00), "energy change not a multiple of four")

    `ISING_ASSERT_CLK(a_result_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid && $stable(spin_after) && $stable(flipped) && $stable(energy_change), "stalled result changed")

endmodule

bind ising_metropolis_spin_update_core ising_checker u_ising_checker (.*);

### bench/ising_metropolis_spin_update_core_test.sv
// Self-checking bench for the Ising lattice update core: site requests against a
// lattice predictor, with threshold settings swept between phases.
// Depends on ising_pkg and ising_metropolis_spin_update_core.
module ising_metropolis_spin_update_core_test
    import ising_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATTICE_SIDE  = 32;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 150;
    localparam int STALL_LIMIT   = 5000;
    localparam int TAIL_CYCLES   = 16;

    // One site request as presented on the input channel.
    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] column;
        logic               load_spin;
        logic [DRAW_W-1:0]  uniform_draw;
    } site_request_t;

    // One result as seen on the output channel.
    typedef struct packed {
        logic    spin_after;
        logic    flipped;
        energy_t energy_change;
    } site_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   action;
    logic [COORD_W-1:0]     row;
    logic [COORD_W-1:0]     column;
    logic                   load_spin;
    logic [DRAW_W-1:0]      uniform_draw;
    logic                   out_valid;
    logic                   out_ready;
    logic                   spin_after;
    logic                   flipped;
    energy_t                energy_change;

    // Predictor state: own copy of the lattice and both thresholds.
    logic                lattice_spin [0:LATTICE_SIDE-1][0:LATTICE_SIDE-1];
    logic [THRESH_W-1:0] thresh_four;
    logic [THRESH_W-1:0] thresh_eight;

    site_request_t pending_requests [$];
    site_result_t  expected_results [$];

    int            mismatch_count;
    int            stall_cycles;
    int            send_idle_pct;
    int            recv_idle_pct;
    logic          request_taken;
    site_request_t next_request;
    site_result_t  oldest_result;
    logic [COORD_W-1:0] hot_row;
    logic [COORD_W-1:0] hot_column;

    ising_metropolis_spin_update_core #(
        .SIDE (LATTICE_SIDE)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .row           (row),
        .column        (column),
        .load_spin     (load_spin),
        .uniform_draw  (uniform_draw),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .spin_after    (spin_after),
        .flipped       (flipped),
        .energy_change (energy_change)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Print one line per mismatch and count it; the run carries on.
    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Apply one request to the predicted lattice and return the result it must give.
    function automatic site_result_t update_site(input site_request_t req);
        site_result_t res;
        int r;
        int c;
        int self_val;
        int neighbor_sum;
        int delta;
        logic take;

        r = int'(req.row) % LATTICE_SIDE;
        c = int'(req.column) % LATTICE_SIDE;
        if (req.action == ACT_LOAD)
        begin
            lattice_spin[r][c] = req.load_spin;
            res.spin_after     = req.load_spin;
            res.flipped        = 1'b0;
            res.energy_change  = '0;
            return res;
        end
        self_val     = lattice_spin[r][c] ? 1 : -1;
        // Sum the four neighbors with wrap on every edge.
        neighbor_sum = (lattice_spin[(r + LATTICE_SIDE - 1) % LATTICE_SIDE][c] ? 1 : -1)
                     + (lattice_spin[(r + 1) % LATTICE_SIDE][c] ? 1 : -1)
                     + (lattice_spin[r][(c + LATTICE_SIDE - 1) % LATTICE_SIDE] ? 1 : -1)
                     + (lattice_spin[r][(c + 1) % LATTICE_SIDE] ? 1 : -1);
        delta = 2 * self_val * neighbor_sum;
        if (delta <= 0)
            take = 1'b1;
        else if (delta == 4)
            take = int'(req.uniform_draw) < int'(thresh_four);
        else
            take = int'(req.uniform_draw) < int'(thresh_eight);
        if (take)
            lattice_spin[r][c] = ~lattice_spin[r][c];
        res.spin_after    = lattice_spin[r][c];
        res.flipped       = take;
        res.energy_change = energy_t'(delta);
        return res;
    endfunction

    task automatic queue_request(input logic act, input int r, input int c,
                                 input logic spin, input int draw);
        site_request_t req;
        req.action       = act;
        req.row          = COORD_W'(r);
        req.column       = COORD_W'(c);
        req.load_spin    = spin;
        req.uniform_draw = DRAW_W'(draw);
        pending_requests.push_back(req);
    endtask

    // Write one threshold register; it is called only while no request is outstanding.
    task automatic write_threshold(input logic [CFG_INDEX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_write_en <= 1'b0;
        if (idx == REG_THRESH_FOUR)
            thresh_four = THRESH_W'(value);
        else
            thresh_eight = THRESH_W'(value);
    endtask

    // Hold until every queued request is accepted and every result has come back.
    task automatic wait_for_drain();
        while (pending_requests.size() != 0 || expected_results.size() != 0 || in_valid)
            @(negedge clk);
    endtask

    function automatic logic [COORD_W-1:0] pick_hot_spot();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return COORD_W'(COORD_RANGE - 1);
            default: return COORD_W'($urandom_range(0, COORD_RANGE - 1));
        endcase
    endfunction

    // Random request: mostly flips clustered around a hot spot so that neighbors
    // interact (and back-to-back requests hit the same rows), draws often sitting
    // right at a threshold to hit the strict compare.
    function automatic site_request_t random_request();
        site_request_t req;
        int edge_thr;

        req.action    = ($urandom_range(0, 99) < 35) ? ACT_LOAD : ACT_FLIP;
        req.load_spin = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 2) == 0)
        begin
            req.row    = COORD_W'($urandom_range(0, COORD_RANGE - 1));
            req.column = COORD_W'($urandom_range(0, COORD_RANGE - 1));
        end
        else
        begin
            req.row    = hot_row + COORD_W'($urandom_range(0, 3)) - COORD_W'(1);
            req.column = hot_column + COORD_W'($urandom_range(0, 3)) - COORD_W'(1);
        end
        if ($urandom_range(0, 1) == 0)
            req.uniform_draw = DRAW_W'($urandom_range(0, (1 << DRAW_W) - 1));
        else
        begin
            edge_thr = $urandom_range(0, 1) ? int'(thresh_four) : int'(thresh_eight);
            req.uniform_draw = DRAW_W'(edge_thr + $urandom_range(0, 2) - 1);
        end
        return req;
    endfunction

    // Driver: present a new request at the falling edge once the previous one
    // has been taken, idling at random; toggle out_ready the same way.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            if (!in_valid || request_taken)
            begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_request = pending_requests.pop_front();
                    in_valid     <= 1'b1;
                    action       <= next_request.action;
                    row          <= next_request.row;
                    column       <= next_request.column;
                    load_spin    <= next_request.load_spin;
                    uniform_draw <= next_request.uniform_draw;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: check results first (they are registered, so never from a request
    // taken at this same edge), then predict for a request taken now.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            request_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    flag_mismatch("result with no request outstanding");
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (spin_after !== oldest_result.spin_after)
                        flag_mismatch($sformatf("spin_after got %0b want %0b",
                                                spin_after, oldest_result.spin_after));
                    if (flipped !== oldest_result.flipped)
                        flag_mismatch($sformatf("flipped got %0b want %0b",
                                                flipped, oldest_result.flipped));
                    if (energy_change !== oldest_result.energy_change)
                        flag_mismatch($sformatf("energy_change got %0d want %0d",
                                                energy_change, oldest_result.energy_change));
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(update_site({action, row, column, load_spin,
                                                        uniform_draw}));
            // Watchdog: end the run if nothing moves for too long.
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int four_setting  [RANDOM_PHASES];
        int eight_setting [RANDOM_PHASES];

        // Negative entries stand for a random setting drawn at run time.
        four_setting  = '{0, 65536, 131071, -1, 32768, 1, -1, 65535, 49152};
        eight_setting = '{0, 131071, 0, -1, 8192, 65535, -1, 65536, 16384};

        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        out_ready      = 1'b0;
        action         = ACT_LOAD;
        row            = '0;
        column         = '0;
        load_spin      = 1'b0;
        uniform_draw   = '0;
        request_taken  = 1'b0;
        mismatch_count = 0;
        stall_cycles   = 0;
        send_idle_pct  = 24;
        recv_idle_pct  = 56;
        thresh_four    = '0;
        thresh_eight   = '0;
        hot_row        = '0;
        hot_column     = '0;
        for (int r = 0; r < LATTICE_SIDE; r++)
            for (int c = 0; c < LATTICE_SIDE; c++)
                lattice_spin[r][c] = 1'b1;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, thresholds at zero: walk the corner site through every energy
        // change, with its neighbors reached across the wrap.
        write_threshold(REG_THRESH_FOUR, 0);
        write_threshold(REG_THRESH_EIGHT, 0);
        queue_request(ACT_FLIP, 0, 0, 1'b0, 0);          // all up: +8, zero threshold rejects
        queue_request(ACT_FLIP, 31, 31, 1'b1, 16'hFFFF); // far corner, top draw
        queue_request(ACT_LOAD, 0, 0, 1'b0, 0);
        queue_request(ACT_FLIP, 0, 0, 1'b1, 16'hFFFF);   // -8 always flips
        queue_request(ACT_LOAD, 31, 0, 1'b0, 0);         // row above through the wrap
        queue_request(ACT_FLIP, 0, 0, 1'b0, 0);          // +4 rejected
        queue_request(ACT_LOAD, 0, 31, 1'b0, 0);         // column left through the wrap
        queue_request(ACT_FLIP, 0, 0, 1'b0, 0);          // zero change flips
        queue_request(ACT_FLIP, 0, 0, 1'b0, 0);          // and flips back
        queue_request(ACT_LOAD, 1, 0, 1'b0, 0);
        queue_request(ACT_FLIP, 0, 0, 1'b0, 0);          // -4 flips
        queue_request(ACT_FLIP, 0, 0, 1'b0, 0);          // +4 rejected
        queue_request(ACT_LOAD, 0, 1, 1'b0, 0);
        queue_request(ACT_FLIP, 0, 0, 1'b0, 0);          // +8 rejected
        queue_request(ACT_LOAD, 31, 31, 1'b0, 16'hFFFF);
        queue_request(ACT_LOAD, 31, 31, 1'b1, 16'hFFFF);
        wait_for_drain();

        // Directed, threshold for +4 above every draw, threshold for +8 at one.
        write_threshold(REG_THRESH_FOUR, 65536);
        write_threshold(REG_THRESH_EIGHT, 1);
        queue_request(ACT_FLIP, 0, 0, 1'b0, 1);          // +8 with draw equal to threshold
        queue_request(ACT_FLIP, 0, 0, 1'b0, 0);          // +8 with draw below threshold
        queue_request(ACT_FLIP, 0, 0, 1'b0, 16'hFFFF);   // -8
        queue_request(ACT_LOAD, 0, 1, 1'b1, 0);
        queue_request(ACT_FLIP, 0, 0, 1'b0, 16'hFFFF);   // +4 at the top draw still accepts
        queue_request(ACT_FLIP, 31, 31, 1'b0, 16'hFFFF); // zero change at the far corner
        wait_for_drain();

        // Random phases: receiver-heavy idling, then sender-heavy, then none.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph < 3)
            begin
                send_idle_pct = 24;
                recv_idle_pct = 56;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 24;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_threshold(REG_THRESH_FOUR, (four_setting[ph] < 0) ?
                            $urandom_range(0, (1 << THRESH_W) - 1) : four_setting[ph]);
            write_threshold(REG_THRESH_EIGHT, (eight_setting[ph] < 0) ?
                            $urandom_range(0, (1 << THRESH_W) - 1) : eight_setting[ph]);
            hot_row    = pick_hot_spot();
            hot_column = pick_hot_spot();
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_requests.push_back(random_request());
            // The sender stays quiet here until every result is back.
            wait_for_drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
